FILE: rtl/core/qc_i2p_pkg.sv
// shared constants, codes and controller/datapath interface types for the infix-to-postfix unit
package qc_i2p_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int TAG_BITS    = 8;

	localparam int IDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int TDATA_W  = ((TAG_BITS + 7) / 8) * 8;
	localparam int KIND_W   = 3;
	localparam int CLS_W    = 2;
	localparam int ERR_W    = 2;
	localparam int ENTRY_W  = CLS_W + TAG_BITS;
	localparam int S_USER_W = KIND_W;
	localparam int M_USER_W = KIND_W + 1 + ERR_W;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [CLS_W-1:0]    cls_t;
	typedef logic [ERR_W-1:0]    err_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [IDX_W-1:0]    idx_t;

	// input token kinds
	localparam kind_t K_OPERAND = 3'd0;
	localparam kind_t K_REL     = 3'd1;
	localparam kind_t K_AND     = 3'd2;
	localparam kind_t K_OR      = 3'd3;
	localparam kind_t K_LPAREN  = 3'd4;
	localparam kind_t K_RPAREN  = 3'd5;

	// output kind for a result that carries only status
	localparam kind_t K_STATUS  = 3'd4;

	// stack entry classes
	localparam cls_t CL_LPAREN = 2'd0;
	localparam cls_t CL_REL    = 2'd1;
	localparam cls_t CL_AND    = 2'd2;
	localparam cls_t CL_OR     = 2'd3;

	// error codes
	localparam err_t ERR_NONE   = 2'd0;
	localparam err_t ERR_RPAREN = 2'd1;
	localparam err_t ERR_FULL   = 2'd2;
	localparam err_t ERR_LPAREN = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture accepted token
		logic pop_emit;  // pop top entry and emit it
		logic pop_drop;  // pop top entry without emitting
		logic push;      // push current token as operator
		logic emit_op;   // emit current token as operand
		logic emit_err;  // emit status result with latched error
		logic err_set;   // record error if none yet
		err_t err_val;
		logic finish;    // close the run of results for this token
	} qc_i2p_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  fin;
		logic  empty;
		cls_t  top_cls;
		logic  err_nz;
		logic  out_free;
	} qc_i2p_stat_t;

endpackage

FILE: rtl/core/query_condition_infix_to_postfix_unit.sv
// top level of the condition infix-to-postfix converter (shunting yard over an operator stack)
//
//  channel  dir  tdata              tuser                               tlast
//  s_axis   in   token_tag          token_kind                          final_token
//  m_axis   out  out_tag            out_kind, expr_end, error_code      run_last
//
// each token passes the idle step that takes its transfer, then the work, flush and error
// steps and its close step; work repeats for each operator popped ahead of its push or by
// a right paren, and flush repeats for each entry removed by the final flush
// the stack is a memory with one write and one registered read of the current top;
// the pop loop runs one entry per cycle while results can move, which sets the rate
// results leave through one output register; a stalled m_axis holds the controller,
// and s_axis is ready only between tokens
// reset clears the stack count, the controller and the valid flags; stack entries are
// never used before they are written
module query_condition_infix_to_postfix_unit import qc_i2p_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [TDATA_W-1:0]  s_axis_tdata,   // token_tag
	input  logic [S_USER_W-1:0] s_axis_tuser,   // token_kind
	input  logic                s_axis_tlast,   // final_token
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [TDATA_W-1:0]  m_axis_tdata,   // out_tag
	output logic [M_USER_W-1:0] m_axis_tuser,   // out_kind, expr_end, error_code
	output logic                m_axis_tlast    // run_last
);

	qc_i2p_cmd_t  cmd;
	qc_i2p_stat_t stat;
	kind_t        out_kind;
	tag_t         out_tag;
	logic         out_end;
	err_t         out_err;

	// sequencing of pops, pushes, flush and the close of each run
	qc_i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// operator stack, token latch and result registers
	qc_i2p_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_kind   (s_axis_tuser[KIND_W-1:0]),
		.in_tag    (s_axis_tdata[TAG_BITS-1:0]),
		.in_fin    (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (out_kind),
		.out_tag   (out_tag),
		.out_last  (m_axis_tlast),
		.out_end   (out_end),
		.out_err   (out_err)
	);

	// pad the tag up to whole bytes
	assign m_axis_tdata = TDATA_W'(out_tag);
	assign m_axis_tuser = {out_err, out_end, out_kind};

endmodule

FILE: rtl/core/qc_i2p_dp.sv
// datapath: token latch, operator stack memory, error latch, result hold and output registers
module qc_i2p_dp import qc_i2p_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  qc_i2p_cmd_t  cmd,
	output qc_i2p_stat_t stat,
	input  kind_t        in_kind,
	input  tag_t         in_tag,
	input  logic         in_fin,
	output logic         out_valid,
	input  logic         out_ready,
	output kind_t        out_kind,
	output tag_t         out_tag,
	output logic         out_last,
	output logic         out_end,
	output err_t         out_err
);

	kind_t  kind_q;
	tag_t   tag_q;
	logic   fin_q;
	err_t   err_q;
	cnt_t   cnt_q;
	cnt_t   cnt_next;
	logic [ENTRY_W-1:0] mem [STACK_DEPTH];
	logic [ENTRY_W-1:0] top_q;
	logic [ENTRY_W-1:0] wdata;
	idx_t   waddr;
	idx_t   raddr;
	logic   full;
	logic   wr;
	cls_t   push_cls;

	logic   hold_valid_q;
	kind_t  hold_kind_q;
	tag_t   hold_tag_q;
	err_t   hold_err_q;

	logic   out_valid_q;
	kind_t  out_kind_q;
	tag_t   out_tag_q;
	err_t   out_err_q;
	logic   out_last_q;
	logic   out_end_q;

	logic   new_valid;
	kind_t  new_kind;
	tag_t   new_tag;
	err_t   new_err;
	logic   out_free;

	assign full     = (cnt_q == cnt_t'(STACK_DEPTH));
	assign wr       = cmd.push && !full;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (kind_q)
			K_REL:   push_cls = CL_REL;
			K_AND:   push_cls = CL_AND;
			K_OR:    push_cls = CL_OR;
			default: push_cls = CL_LPAREN;
		endcase
	end

	assign wdata = {push_cls, tag_q};
	assign waddr = cnt_q[IDX_W-1:0];

	always_comb begin
		cnt_next = cnt_q;
		if (cmd.pop_emit || cmd.pop_drop)
			cnt_next = cnt_q - cnt_t'(1);
		else if (wr)
			cnt_next = cnt_q + cnt_t'(1);
	end

	// read address tracks the top of the stack as it will be after this cycle
	assign raddr = cnt_next[IDX_W-1:0] - idx_t'(1);

	always_ff @(posedge clk) begin
		if (wr)
			mem[waddr] <= wdata;
		top_q <= (wr && waddr == raddr) ? wdata : mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			tag_q  <= in_tag;
			fin_q  <= in_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= ERR_NONE;
		end else if (cmd.load) begin
			err_q <= ERR_NONE;
		end else if (err_q == ERR_NONE) begin
			if (cmd.push && full)
				err_q <= ERR_FULL;
			else if (cmd.err_set)
				err_q <= cmd.err_val;
		end
	end

	// new result source
	always_comb begin
		new_valid = cmd.pop_emit || cmd.emit_op || cmd.emit_err;
		new_kind  = K_STATUS;
		new_tag   = '0;
		new_err   = ERR_NONE;
		if (cmd.pop_emit) begin
			new_kind = {1'b0, top_q[ENTRY_W-1 -: CLS_W]};
			new_tag  = top_q[TAG_BITS-1:0];
		end else if (cmd.emit_op) begin
			new_kind = K_OPERAND;
			new_tag  = tag_q;
		end else if (cmd.emit_err) begin
			new_err  = err_q;
		end
	end

	// one result waits in hold until the next one shows whether it was the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (new_valid) begin
			hold_valid_q <= 1'b1;
		end else if (cmd.finish) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (new_valid) begin
			hold_kind_q <= new_kind;
			hold_tag_q  <= new_tag;
			hold_err_q  <= new_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((new_valid && hold_valid_q) || (cmd.finish && (hold_valid_q || fin_q))) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (new_valid && hold_valid_q) begin
			out_kind_q <= hold_kind_q;
			out_tag_q  <= hold_tag_q;
			out_err_q  <= hold_err_q;
			out_last_q <= 1'b0;
			out_end_q  <= 1'b0;
		end else if (cmd.finish && hold_valid_q) begin
			out_kind_q <= hold_kind_q;
			out_tag_q  <= hold_tag_q;
			out_err_q  <= hold_err_q;
			out_last_q <= 1'b1;
			out_end_q  <= fin_q;
		end else if (cmd.finish && fin_q) begin
			out_kind_q <= K_STATUS;
			out_tag_q  <= '0;
			out_err_q  <= ERR_NONE;
			out_last_q <= 1'b1;
			out_end_q  <= 1'b1;
		end
	end

	assign stat.kind     = kind_q;
	assign stat.fin      = fin_q;
	assign stat.empty    = (cnt_q == '0);
	assign stat.top_cls  = top_q[ENTRY_W-1 -: CLS_W];
	assign stat.err_nz   = (err_q != ERR_NONE);
	assign stat.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_tag   = out_tag_q;
	assign out_last  = out_last_q;
	assign out_end   = out_end_q;
	assign out_err   = out_err_q;

endmodule

FILE: rtl/core/qc_i2p_ctrl.sv
// controller: sequences the pop, push, flush and close steps for each token
module qc_i2p_ctrl import qc_i2p_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  qc_i2p_stat_t stat,
	output qc_i2p_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WORK,
		ST_FLUSH,
		ST_ERR,
		ST_END
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;
	logic   go;

	// every busy step may move a result into the output register
	assign go       = stat.out_free;
	assign in_ready = ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && ready_q) begin
					cmd.load = 1'b1;
					state_d  = ST_WORK;
				end
			end
			ST_WORK: begin
				if (go) begin
					case (stat.kind)
						K_OPERAND: begin
							cmd.emit_op = 1'b1;
							state_d     = ST_FLUSH;
						end
						K_REL: begin
							if (!stat.empty && stat.top_cls == CL_REL) begin
								cmd.pop_emit = 1'b1;
							end else begin
								cmd.push = 1'b1;
								state_d  = ST_FLUSH;
							end
						end
						K_AND: begin
							if (!stat.empty && (stat.top_cls inside {CL_REL, CL_AND})) begin
								cmd.pop_emit = 1'b1;
							end else begin
								cmd.push = 1'b1;
								state_d  = ST_FLUSH;
							end
						end
						K_OR: begin
							if (!stat.empty && stat.top_cls != CL_LPAREN) begin
								cmd.pop_emit = 1'b1;
							end else begin
								cmd.push = 1'b1;
								state_d  = ST_FLUSH;
							end
						end
						K_LPAREN: begin
							cmd.push = 1'b1;
							state_d  = ST_FLUSH;
						end
						K_RPAREN: begin
							if (!stat.empty && stat.top_cls != CL_LPAREN) begin
								cmd.pop_emit = 1'b1;
							end else if (!stat.empty) begin
								cmd.pop_drop = 1'b1;
								state_d      = ST_FLUSH;
							end else begin
								cmd.err_set = 1'b1;
								cmd.err_val = ERR_RPAREN;
								state_d     = ST_FLUSH;
							end
						end
						default: begin
							state_d = ST_FLUSH;
						end
					endcase
				end
			end
			ST_FLUSH: begin
				if (go) begin
					if (stat.fin && !stat.empty) begin
						if (stat.top_cls == CL_LPAREN) begin
							cmd.pop_drop = 1'b1;
							cmd.err_set  = 1'b1;
							cmd.err_val  = ERR_LPAREN;
						end else begin
							cmd.pop_emit = 1'b1;
						end
					end else begin
						state_d = ST_ERR;
					end
				end
			end
			ST_ERR: begin
				if (go) begin
					cmd.emit_err = stat.err_nz;
					state_d      = ST_END;
				end
			end
			ST_END: begin
				if (go) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == ST_IDLE);
		end
	end

endmodule

FILE: verif/qc_i2p_checker.sv
// stream checker: predicts the postfix results of accepted tokens and compares them
module qc_i2p_checker import qc_i2p_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [TDATA_W-1:0]  s_axis_tdata,
	input  logic [S_USER_W-1:0] s_axis_tuser,
	input  logic                s_axis_tlast,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [TDATA_W-1:0]  m_axis_tdata,
	input  logic [M_USER_W-1:0] m_axis_tuser,
	input  logic                m_axis_tlast,
	output int unsigned         fail_count,
	output int unsigned         results_owed
);

	typedef struct packed {
		kind_t kind;
		tag_t  tag;
		logic  run_last;
		logic  expr_end;
		err_t  err;
	} postfix_t;

	postfix_t    owed_q[$];
	postfix_t    step_q[$];
	err_t        step_err;
	cls_t        op_cls[STACK_DEPTH];
	tag_t        op_tag[STACK_DEPTH];
	int unsigned depth;

	function automatic cls_t top_cls();
		return op_cls[depth-1];
	endfunction

	// one token carries at most a full stack of pops plus one status
	function automatic void add_result(kind_t kind, tag_t tag, err_t err);
		postfix_t r;
		if (step_q.size() >= STACK_DEPTH + 1)
			return;
		r.kind     = kind;
		r.tag      = tag;
		r.run_last = 1'b0;
		r.expr_end = 1'b0;
		r.err      = err;
		step_q = {step_q, r};
	endfunction

	// only the first error of a token is reported
	function automatic void note_err(err_t err);
		if (step_err == ERR_NONE)
			step_err = err;
	endfunction

	function automatic void pop_out();
		depth--;
		add_result(kind_t'({1'b0, op_cls[depth]}), op_tag[depth], ERR_NONE);
	endfunction

	function automatic void push_op(cls_t cls, tag_t tag);
		if (depth >= STACK_DEPTH) begin
			note_err(ERR_FULL);
			return;
		end
		op_cls[depth] = cls;
		op_tag[depth] = tag;
		depth++;
	endfunction

	function automatic void predict_postfix(kind_t kind, tag_t tag, logic fin);
		postfix_t r;
		step_q.delete();
		step_err = ERR_NONE;
		case (kind)
			K_OPERAND: add_result(K_OPERAND, tag, ERR_NONE);
			K_REL: begin
				while (depth > 0 && top_cls() == CL_REL)
					pop_out();
				push_op(CL_REL, tag);
			end
			K_AND: begin
				while (depth > 0 && (top_cls() == CL_REL || top_cls() == CL_AND))
					pop_out();
				push_op(CL_AND, tag);
			end
			K_OR: begin
				while (depth > 0 && top_cls() != CL_LPAREN)
					pop_out();
				push_op(CL_OR, tag);
			end
			K_LPAREN: push_op(CL_LPAREN, tag);
			K_RPAREN: begin
				while (depth > 0 && top_cls() != CL_LPAREN)
					pop_out();
				if (depth > 0)
					depth--;
				else
					note_err(ERR_RPAREN);
			end
			default: ;
		endcase
		if (fin) begin
			while (depth > 0) begin
				if (top_cls() == CL_LPAREN) begin
					depth--;
					note_err(ERR_LPAREN);
				end else begin
					pop_out();
				end
			end
		end
		if (step_err != ERR_NONE)
			add_result(K_STATUS, '0, step_err);
		if (fin && step_q.size() == 0)
			add_result(K_STATUS, '0, ERR_NONE);
		if (step_q.size() > 0) begin
			r          = step_q[step_q.size()-1];
			r.run_last = 1'b1;
			r.expr_end = fin;
			step_q[step_q.size()-1] = r;
		end
		foreach (step_q[i])
			owed_q = {owed_q, step_q[i]};
	endfunction

	function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		postfix_t want;
		postfix_t got;
		if (!arst_n) begin
			depth = 0;
			owed_q.delete();
			fail_count = 0;
			results_owed <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_postfix(kind_t'(s_axis_tuser), s_axis_tdata[TAG_BITS-1:0], s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind     = m_axis_tuser[KIND_W-1:0];
				got.expr_end = m_axis_tuser[KIND_W];
				got.err      = m_axis_tuser[KIND_W+1 +: ERR_W];
				got.tag      = m_axis_tdata[TAG_BITS-1:0];
				got.run_last = m_axis_tlast;
				if (owed_q.size() == 0) begin
					$error("result with nothing owed: out_kind %0d out_tag %0d",
						got.kind, got.tag);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					check_field("out_kind", 16'(want.kind), 16'(got.kind));
					check_field("out_tag", 16'(want.tag), 16'(got.tag));
					check_field("run_last", 16'(want.run_last), 16'(got.run_last));
					check_field("expr_end", 16'(want.expr_end), 16'(got.expr_end));
					check_field("error_code", 16'(want.err), 16'(got.err));
				end
			end
			results_owed <= owed_q.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
// testbench top: drives condition token streams into the converter and reports the verdict
module tb_top;
	import qc_i2p_pkg::*;

	// token kinds the converter ignores; a final one still flushes the stack
	localparam kind_t K_SPARE_LO = 3'd6;
	localparam kind_t K_SPARE_HI = 3'd7;

	localparam int LONG_HOLD  = 300;  // receiver hold-off, long enough to back up s_axis
	localparam int DRAIN_WAIT = 60;   // margin for draining the last token plus a full flush

	typedef struct packed {
		kind_t kind;
		tag_t  tag;
		logic  fin;
	} token_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata;   // token_tag
	logic [S_USER_W-1:0] s_axis_tuser;   // token_kind
	logic                s_axis_tlast;   // final_token
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [TDATA_W-1:0]  m_axis_tdata;   // out_tag
	logic [M_USER_W-1:0] m_axis_tuser;   // out_kind, expr_end, error_code
	logic                m_axis_tlast;   // run_last

	int unsigned fail_count;
	int unsigned results_owed;

	// idle chances in percent, changed per phase by the stimulus
	int unsigned send_idle   = 0;
	int unsigned recv_idle   = 0;
	// long hold-offs asked by the stimulus and served by the receiver
	int unsigned holds_asked = 0;
	int unsigned holds_done  = 0;
	// tokens the converter acts on; ignored kinds count only when final
	int unsigned tokens_sent = 0;

	token_t tok_q[$];

	query_condition_infix_to_postfix_unit dut (.*);

	qc_i2p_checker chk (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// run limit, far above the slowest legal run
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random back-pressure, plus long hold-offs on request
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// offer one token and return at the edge of its transfer; valid stays high after it
	task automatic send_token(kind_t kind, tag_t tag, logic fin);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= TDATA_W'(tag);
		s_axis_tuser  <= kind;
		s_axis_tlast  <= fin;
		// ready is stable mid-cycle, so sample it on the falling edge
		do
			@(negedge clk);
		while (!s_axis_tready);
		@(posedge clk);
		if (kind <= K_RPAREN || fin)
			tokens_sent++;
	endtask

	// sender pauses until every owed result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	function automatic void add_tok(kind_t kind);
		token_t t;
		t.kind = kind;
		t.tag  = tag_t'($urandom);
		t.fin  = 1'b0;
		tok_q = {tok_q, t};
	endfunction

	// grammar: expr = term {or term}, term = factor {and factor},
	// factor = operand | operand rel operand | ( expr )
	function automatic void gen_factor(int unsigned lvl);
		int unsigned pick = $urandom_range(9);
		if (lvl > 0 && pick < 3) begin
			add_tok(K_LPAREN);
			gen_expr(lvl - 1);
			add_tok(K_RPAREN);
		end else if (pick < 7) begin
			add_tok(K_OPERAND);
			add_tok(K_REL);
			add_tok(K_OPERAND);
		end else begin
			add_tok(K_OPERAND);
		end
	endfunction

	function automatic void gen_term(int unsigned lvl);
		int unsigned n_and = $urandom_range(2);
		for (int i = 0; i <= n_and; i++) begin
			if (i > 0)
				add_tok(K_AND);
			gen_factor(lvl);
		end
	endfunction

	function automatic void gen_expr(int unsigned lvl);
		int unsigned n_or = $urandom_range(2);
		for (int i = 0; i <= n_or; i++) begin
			if (i > 0)
				add_tok(K_OR);
			gen_term(lvl);
		end
	endfunction

	// deep nesting that can run into a full stack and can leave parens open at the flush
	function automatic void gen_deep();
		int unsigned opens  = $urandom_range(13, 19);
		int unsigned closes = $urandom_range(opens);
		repeat (opens) add_tok(K_LPAREN);
		add_tok(K_OPERAND);
		if ($urandom_range(1)) begin
			add_tok(K_REL);
			add_tok(K_OPERAND);
		end
		repeat (closes) add_tok(K_RPAREN);
	endfunction

	function automatic void mark_last_final();
		token_t t;
		t     = tok_q[tok_q.size()-1];
		t.fin = 1'b1;
		tok_q[tok_q.size()-1] = t;
	endfunction

	// break a well-formed expression: drop a token, insert a stray one, or flip one token's final flag
	function automatic void break_expr();
		token_t t;
		int unsigned pos = $urandom_range(tok_q.size() - 1);
		case ($urandom_range(2))
			0: if (tok_q.size() > 1) tok_q.delete(pos);
			1: begin
				t.kind = kind_t'($urandom);
				t.tag  = tag_t'($urandom);
				t.fin  = 1'($urandom_range(1));
				tok_q.insert(pos, t);
			end
			default: begin
				t        = tok_q[pos];
				t.fin    = ~t.fin;
				tok_q[pos] = t;
			end
		endcase
	endfunction

	task automatic send_queued();
		foreach (tok_q[i])
			send_token(tok_q[i].kind, tok_q[i].tag, tok_q[i].fin);
		tok_q.delete();
	endtask

	// mostly well-formed expressions with random content, the rest deep or broken or noise
	task automatic run_phase(int unsigned s_idle, int unsigned r_idle, int unsigned count);
		int unsigned goal = tokens_sent + count;
		int unsigned pause_at = tokens_sent + count / 2;
		bit paused = 1'b0;
		send_idle = s_idle;
		recv_idle = r_idle;
		while (tokens_sent < goal) begin
			case ($urandom_range(9))
				0: begin
					gen_deep();
					mark_last_final();
				end
				1: begin
					gen_expr($urandom_range(2));
					mark_last_final();
					break_expr();
				end
				2: begin
					tok_q.delete();
					add_tok(kind_t'($urandom));
					if ($urandom_range(3) == 0)
						mark_last_final();
				end
				default: begin
					gen_expr($urandom_range(3));
					mark_last_final();
				end
			endcase
			send_queued();
			if (!paused && tokens_sent >= pause_at) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, tag extremes and both paren error paths
		recv_idle = 30;
		send_token(K_OPERAND, 8'h00, 1'b0);
		send_token(K_REL, 8'hff, 1'b0);
		send_token(K_OPERAND, 8'ha5, 1'b0);
		send_token(K_AND, 8'h5a, 1'b0);       // pops the relational
		send_token(K_LPAREN, 8'h01, 1'b0);
		send_token(K_OPERAND, 8'h80, 1'b0);
		send_token(K_OR, 8'h7f, 1'b0);        // stops at the left paren
		send_token(K_OPERAND, 8'hc3, 1'b0);
		send_token(K_RPAREN, 8'h3c, 1'b0);    // pops or, drops the paren pair
		send_token(K_RPAREN, 8'h10, 1'b0);    // no left paren: empties stack, reports error
		send_token(K_SPARE_LO, 8'h20, 1'b0);  // ignored, no result
		send_token(K_SPARE_HI, 8'h40, 1'b1);  // ignored but final: status-only result
		send_token(K_LPAREN, 8'h02, 1'b0);    // push only, nothing emitted
		send_token(K_RPAREN, 8'h04, 1'b1);    // final with no token: status-only result
		send_token(K_OPERAND, 8'h08, 1'b1);   // lone operand ends an expression
		send_token(K_OPERAND, 8'h11, 1'b0);
		send_token(K_OR, 8'h22, 1'b0);
		send_token(K_OPERAND, 8'h44, 1'b0);
		send_token(K_AND, 8'h88, 1'b0);
		send_token(K_LPAREN, 8'hee, 1'b0);
		send_token(K_OPERAND, 8'h77, 1'b1);   // flush meets an open paren
		wait_drained();

		// receiver holds off while the sender keeps offering, so the input backs up
		holds_asked++;
		run_phase(10, 58, 100);
		run_phase(58, 10, 95);
		run_phase(0, 0, 95);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: query_condition_infix_to_postfix_unit.f
rtl/core/qc_i2p_pkg.sv
rtl/core/qc_i2p_dp.sv
rtl/core/qc_i2p_ctrl.sv
rtl/core/query_condition_infix_to_postfix_unit.sv
verif/qc_i2p_checker.sv
verif/tb_top.sv
